/* sv/rgbhsl_pkg.sv */
// Shared types and constants for the RGB to HSL converter.
`default_nettype none

package rgbhsl_pkg;

	localparam int CHAN_W = 8;
	localparam int SUM_W = CHAN_W + 1;
	localparam int HUE_W = 15;
	localparam int Q15_W = 16;
	localparam int M_W = 11;

	localparam int NUM_W = 25;
	localparam int DEN_W = 10;
	localparam int QUO_W = 16;

	localparam int OUT_STAGE = QUO_W + 1;

	localparam int LZ_W = 16;
	localparam int LP_W = 32;
	localparam int LIGHT_SHIFT = 24;

	localparam logic [QUO_W-1:0] HUE_TURN = QUO_W'(23040);
	localparam logic [SUM_W-1:0] HALF_SUM = SUM_W'(255);
	localparam logic [SUM_W-1:0] FULL_SUM = SUM_W'(510);
	localparam logic [LZ_W-1:0]  LIGHT_RND = LZ_W'(255);
	localparam logic [LZ_W-1:0]  LIGHT_RECIP = LZ_W'(32897);

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_RED_WRAP,
		SEC_GREEN,
		SEC_BLUE
	} sec_t;

	typedef struct packed {
		logic [CHAN_W-1:0] d;
		logic [SUM_W-1:0]  sum;
		logic [CHAN_W-1:0] f;
		sec_t              sec;
		logic              neg;
	} item_t;

	typedef struct packed {
		logic  vld;
		item_t item;
	} head_t;

endpackage

`default_nettype wire

/* sv/rgbhsl_front.sv */
// Front end: accepts pixels, finds max and min and classifies the hue sector.
`default_nettype none

module rgbhsl_front (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_stall,
	input  wire  [7:0]                red,
	input  wire  [7:0]                green,
	input  wire  [7:0]                blue,
	input  wire                       q_full,
	output logic                      push,
	output rgbhsl_pkg::item_t         push_item
);
	import rgbhsl_pkg::*;

	logic              vld_s1;
	item_t             item_s1;
	item_t             cls;
	logic [CHAN_W-1:0] mx;
	logic [CHAN_W-1:0] mn;
	logic              take;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		cls.d = mx - mn;
		cls.sum = SUM_W'(mx) + SUM_W'(mn);
		if (mx == red) begin
			if (green >= blue) begin
				cls.sec = SEC_RED;
				cls.neg = 1'b0;
				cls.f = green - blue;
			end else begin
				cls.sec = SEC_RED_WRAP;
				cls.neg = 1'b1;
				cls.f = blue - green;
			end
		end else if (mx == green) begin
			cls.sec = SEC_GREEN;
			cls.neg = (blue < red);
			cls.f = (blue >= red) ? blue - red : red - blue;
		end else begin
			cls.sec = SEC_BLUE;
			cls.neg = (red < green);
			cls.f = (red >= green) ? red - green : green - red;
		end
	end

	assign in_stall = vld_s1 & q_full;
	assign push = vld_s1 & ~q_full;
	assign push_item = item_s1;
	assign take = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= cls;
		end
	end

endmodule

`default_nettype wire

/* sv/rgbhsl_queue.sv */
// Two-entry queue between the front end and the back end.
`default_nettype none

module rgbhsl_queue (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       push,
	input  rgbhsl_pkg::item_t         push_item,
	output logic                      full,
	input  wire                       pop,
	output rgbhsl_pkg::head_t         head
);
	import rgbhsl_pkg::*;

	item_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign head.vld = (cnt_q != 2'd0);
	assign head.item = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

/* sv/rgbhsl_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module rgbhsl_div (
	input  wire                              clk,
	input  wire                              en,
	input  wire  [rgbhsl_pkg::NUM_W-1:0]     num,
	input  wire  [rgbhsl_pkg::DEN_W-1:0]     den,
	output logic [rgbhsl_pkg::QUO_W-1:0]     quo
);
	import rgbhsl_pkg::*;

	logic [NUM_W-1:0] rem_q [QUO_W-1];
	logic [DEN_W-1:0] den_q [QUO_W-1];
	logic [QUO_W-1:0] quo_q [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [NUM_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;
		logic [NUM_W:0]   dsh;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign den_in = den_q[k-1];
			assign quo_in = quo_q[k-1];
		end

		assign dsh = (NUM_W+1)'(den_in) << (QUO_W - 1 - k);
		assign ge = ({1'b0, rem_in} >= dsh);

		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[k] <= quo_in | (ge ? (QUO_W'(1) << (QUO_W - 1 - k)) : '0);
			end
		end

		if (k < QUO_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k] <= ge ? rem_in - dsh[NUM_W-1:0] : rem_in;
					den_q[k] <= den_in;
				end
			end
		end
	end

	assign quo = quo_q[QUO_W-1];

endmodule

`default_nettype wire

/* sv/rgbhsl_back.sv */
// Back end: builds the divider operands, runs the dividers, computes lightness and holds the result.
`default_nettype none

module rgbhsl_back (
	input  wire                               clk,
	input  wire                               arst_n,
	input  rgbhsl_pkg::head_t                 head,
	output logic                              pop,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic [rgbhsl_pkg::HUE_W-1:0]      hue,
	output logic [rgbhsl_pkg::Q15_W-1:0]      lightness,
	output logic [rgbhsl_pkg::Q15_W-1:0]      saturation
);
	import rgbhsl_pkg::*;

	logic [OUT_STAGE:0] vld_q;
	logic [QUO_W:0]     grey_q;
	logic [QUO_W:0][SUM_W-1:0] sum_q;
	logic               adv;

	logic [M_W-1:0]   kd;
	logic [M_W-1:0]   m;
	logic [SUM_W-1:0] sden;

	logic [LZ_W-1:0]  lz;
	logic [LP_W-1:0]  lprod;
	logic [Q15_W-1:0] lval;

	logic [NUM_W-1:0] hnum_s0;
	logic [DEN_W-1:0] hden_s0;
	logic [NUM_W-1:0] snum_s0;
	logic [DEN_W-1:0] sden_s0;

	logic [QUO_W-1:0] hquo;
	logic [QUO_W-1:0] squo;

	logic [HUE_W-1:0] hue_q;
	logic [Q15_W-1:0] light_q;
	logic [Q15_W-1:0] sat_q;

	assign adv = ~vld_q[OUT_STAGE] | ~out_stall;
	assign pop = adv & head.vld;

	always_comb begin
		case (head.item.sec)
			SEC_RED:      kd = '0;
			SEC_RED_WRAP: kd = M_W'({head.item.d, 2'b0}) + M_W'({head.item.d, 1'b0});
			SEC_GREEN:    kd = M_W'({head.item.d, 1'b0});
			SEC_BLUE:     kd = M_W'({head.item.d, 2'b0});
			default:      kd = '0;
		endcase
		m = head.item.neg ? kd - M_W'(head.item.f) : kd + M_W'(head.item.f);
		sden = (head.item.sum <= HALF_SUM) ? head.item.sum : FULL_SUM - head.item.sum;
		// Lightness is 64*sum plus round(64*sum/255), the latter by reciprocal multiply.
		lz = LZ_W'({sum_q[QUO_W], 7'b0}) + LIGHT_RND;
		lprod = LP_W'(lz) * LP_W'(LIGHT_RECIP);
		lval = Q15_W'({sum_q[QUO_W], 6'b0}) + Q15_W'(lprod[LP_W-1:LIGHT_SHIFT]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[OUT_STAGE-1:0], head.vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			grey_q <= {grey_q[QUO_W-1:0], (head.item.d == '0)};
			sum_q <= {sum_q[QUO_W-1:0], head.item.sum};
			hnum_s0 <= NUM_W'({m, 13'b0}) - NUM_W'({m, 9'b0}) + NUM_W'(head.item.d);
			hden_s0 <= DEN_W'({head.item.d, 1'b0});
			snum_s0 <= NUM_W'({head.item.d, 16'b0}) + NUM_W'(sden);
			sden_s0 <= DEN_W'({sden, 1'b0});
			if (grey_q[QUO_W]) begin
				hue_q <= '0;
				sat_q <= '0;
			end else begin
				hue_q <= (hquo >= HUE_TURN) ? HUE_W'(hquo - HUE_TURN) : HUE_W'(hquo);
				sat_q <= squo;
			end
			light_q <= lval;
		end
	end

	rgbhsl_div u_hue_div (
		.clk (clk),
		.en  (adv),
		.num (hnum_s0),
		.den (hden_s0),
		.quo (hquo)
	);

	rgbhsl_div u_sat_div (
		.clk (clk),
		.en  (adv),
		.num (snum_s0),
		.den (sden_s0),
		.quo (squo)
	);

	assign out_valid = vld_q[OUT_STAGE];
	assign hue = hue_q;
	assign lightness = light_q;
	assign saturation = sat_q;

endmodule

`default_nettype wire

/* sv/rgb_to_hsl_convert_top.sv */
// Top level of the RGB to HSL converter.
// Throughput: one pixel per cycle while the output is not stalled.
// The 16-stage dividers in the back end make up most of the pipeline.
// At full rate the two-entry queue lets the front end take one more pixel after the output stalls.
// Reset clears all valid flags and queue pointers; data registers are not reset.
`default_nettype none

module rgb_to_hsl_convert_top (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire  [7:0]                        red,
	input  wire  [7:0]                        green,
	input  wire  [7:0]                        blue,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic [rgbhsl_pkg::HUE_W-1:0]      hue,
	output logic [rgbhsl_pkg::Q15_W-1:0]      lightness,
	output logic [rgbhsl_pkg::Q15_W-1:0]      saturation
);
	import rgbhsl_pkg::*;

	logic  q_full;
	logic  push;
	item_t push_item;
	logic  pop;
	head_t head;

	rgbhsl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	rgbhsl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head      (head)
	);

	rgbhsl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hue        (hue),
		.lightness  (lightness),
		.saturation (saturation)
	);

endmodule

`default_nettype wire

/* sv/rgbhsl_checker.sv */
// Port-level checks for the RGB to HSL converter and their binding.
`default_nettype none

module rgbhsl_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire [7:0]  red,
	input wire [7:0]  green,
	input wire [7:0]  blue,
	input wire        out_valid,
	input wire        out_stall,
	input wire [14:0] hue,
	input wire [15:0] lightness,
	input wire [15:0] saturation
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("A stalled result item was dropped.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hue) && $stable(lightness) && $stable(saturation))
		else $error("A stalled result item changed.");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hue < 15'd23040)
		else $error("Hue is past a full turn.");

	a_q15_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lightness <= 16'd32768 && saturation <= 16'd32768)
		else $error("Lightness or saturation is above one.");

	a_hue_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hue != 15'd0 |-> saturation != 16'd0)
		else $error("A colored item has zero saturation.");

endmodule

bind rgb_to_hsl_convert_top rgbhsl_checker u_rgbhsl_checker (.*);

`default_nettype wire
